### src/ltpc_pkg.sv
// Shared types and constants for the lower-triangle prime counter.
// No dependencies; every other file in src except ltpc_in_if imports this package.
package ltpc_pkg;

  // Result count width and its saturation ceiling
  localparam int unsigned COUNT_W   = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  // Smallest prime, also the first trial divisor
  localparam int unsigned FIRST_DIVISOR = 2;

  // Outcome of one primality test, pulsed for one cycle
  typedef struct packed {
    logic done;
    logic prime;
  } trial_res_t;

  // Top-level control states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TEST = 3'b010,
    S_FIN  = 3'b100
  } top_state_t;

  // Trial-division sequencer states
  typedef enum logic [3:0] {
    T_IDLE   = 4'b0001,
    T_LAUNCH = 4'b0010,
    T_RUN    = 4'b0100,
    T_NEXT   = 4'b1000
  } trial_state_t;

endpackage

### src/ltpc_in_if.sv
// Input channel: one matrix element per item, valid/ready handshake.
// Depends on nothing beyond the VALUE_BITS parameter.
interface ltpc_in_if #(
  parameter int VALUE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [5:0]                   row_index;
  logic [5:0]                   col_index;
  logic signed [VALUE_BITS-1:0] element_value;
  logic                         last_element;

  modport source (
    output valid, row_index, col_index, element_value, last_element,
    input  ready
  );
  modport sink (
    input  valid, row_index, col_index, element_value, last_element,
    output ready
  );
endinterface

### src/ltpc_out_if.sv
// Result channel: one prime count per item, valid/ready handshake.
// Depends on ltpc_pkg for the count width.
interface ltpc_out_if;
  import ltpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] prime_count;

  modport source (
    output valid, prime_count,
    input  ready
  );
  modport sink (
    input  valid, prime_count,
    output ready
  );
endinterface

### src/ltpc_rem.sv
// Shared remainder unit: restoring division, one dividend bit per cycle.
// Depends on ltpc_pkg (imported for house consistency, no types used).
module ltpc_rem #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] rem
);
  import ltpc_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] dvd_r, dvd_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS:0]   trial_w;
  logic [VALUE_BITS:0]   diff_w;
  logic                  fits_w;

  // One restoring step: shift in next dividend bit, subtract if it fits
  assign trial_w = {rem_r, dvd_r[VALUE_BITS-1]};
  assign diff_w  = trial_w - {1'b0, divisor};
  assign fits_w  = trial_w >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_BITS - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits_w ? diff_w[VALUE_BITS-1:0] : trial_w[VALUE_BITS-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  // A new division is only launched when the unit is free
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("remainder unit restarted while busy");

  // Completion follows the final step of a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("remainder done without a running division");

  // Remainder is always below the divisor once finished
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < divisor)
    else $error("remainder not below divisor");

endmodule

### src/ltpc_trial.sv
// Trial-division sequencer: steps divisors 2,3,5,7,.. while d*d <= value.
// Depends on ltpc_pkg and the shared remainder unit ltpc_rem.
module ltpc_trial #(
  parameter int VALUE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_BITS-1:0]  value,
  output ltpc_pkg::trial_res_t   res
);
  import ltpc_pkg::*;

  localparam int SQ_W = VALUE_BITS + 2;

  trial_state_t          state_r, state_nxt;
  trial_res_t            res_r, res_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic                  rem_start;
  logic                  rem_done;
  logic [VALUE_BITS-1:0] rem_val;
  logic [SQ_W-1:0]       sq_step;

  ltpc_rem #(
    .VALUE_BITS(VALUE_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (val_r),
    .divisor  (d_r),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // (d+2)^2 = d^2 + 4d + 4
  assign sq_step = sq_r + {d_r, 2'b00} + SQ_W'(4);

  always_comb begin
    state_nxt = state_r;
    res_nxt   = '0;
    val_nxt   = val_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    rem_start = 1'b0;
    case (state_r)
      T_IDLE: begin
        if (start) begin
          val_nxt = value;
          d_nxt   = VALUE_BITS'(FIRST_DIVISOR);
          sq_nxt  = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
          // negatives, 0 and 1 are not prime; 2 and 3 need no division
          if (value[VALUE_BITS-1] || value < VALUE_BITS'(FIRST_DIVISOR)) begin
            res_nxt = '{done: 1'b1, prime: 1'b0};
          end else if ({2'b00, value} < SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR)) begin
            res_nxt = '{done: 1'b1, prime: 1'b1};
          end else begin
            state_nxt = T_LAUNCH;
          end
        end
      end
      T_LAUNCH: begin
        rem_start = 1'b1;
        state_nxt = T_RUN;
      end
      T_RUN: begin
        if (rem_done) begin
          if (rem_val == '0) begin
            res_nxt   = '{done: 1'b1, prime: 1'b0};
            state_nxt = T_IDLE;
          end else begin
            state_nxt = T_NEXT;
          end
        end
      end
      T_NEXT: begin
        // after 2 only odd divisors are tried
        if (d_r == VALUE_BITS'(FIRST_DIVISOR)) begin
          d_nxt  = VALUE_BITS'(FIRST_DIVISOR + 1);
          sq_nxt = SQ_W'((FIRST_DIVISOR + 1) * (FIRST_DIVISOR + 1));
        end else begin
          d_nxt  = d_r + VALUE_BITS'(2);
          sq_nxt = sq_step;
        end
        if (sq_nxt > {2'b00, val_r}) begin
          res_nxt   = '{done: 1'b1, prime: 1'b1};
          state_nxt = T_IDLE;
        end else begin
          state_nxt = T_LAUNCH;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
  end

  assign res = res_r;

  // Remainder results only arrive while a division is awaited
  a_rem_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> state_r == T_RUN)
    else $error("remainder done outside run state");

  // Divisor squared tracks the divisor whenever a division is launched
  a_sq_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == T_LAUNCH |-> sq_r == SQ_W'(d_r) * SQ_W'(d_r))
    else $error("divisor square out of step");

  // A finished test leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.done |-> state_r == T_IDLE)
    else $error("result pulsed while sequencer busy");

endmodule

### src/lower_triangle_prime_counter_unit.sv
// Each element under test is trial-divided (2, then odd d while d*d <= value),
// stopping at the first divisor that divides the value; values below 4 need none.
// One item at a time, limited by the bit-serial remainder unit. Synchronous
// active-low reset clears the count, the sequencers and the result valid flag;
// the result count register itself has no reset.
module lower_triangle_prime_counter_unit #(
  parameter int MAX_DIM    = 64,
  parameter int VALUE_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  ltpc_in_if.sink  in_if,
  ltpc_out_if.source out_if
);
  import ltpc_pkg::*;

  top_state_t         state_r, state_nxt;
  logic               last_r, last_nxt;
  logic               incr_r, incr_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               in_fire;
  logic               in_lower;
  logic               slot_free;
  logic [COUNT_W-1:0] count_sum;
  trial_res_t         tres;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;

  // Strictly below the diagonal and inside the matrix
  assign in_lower = (int'(in_if.row_index) < MAX_DIM) &&
                    (int'(in_if.col_index) < MAX_DIM) &&
                    (in_if.row_index > in_if.col_index);

  ltpc_trial #(
    .VALUE_BITS(VALUE_BITS)
  ) u_trial (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire && in_lower),
    .value (in_if.element_value),
    .res   (tres)
  );

  // Saturating update of the running count
  assign count_sum = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(incr_r);
  assign slot_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    incr_nxt      = incr_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_count_nxt = out_count_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt  = in_if.last_element;
          incr_nxt  = 1'b0;
          state_nxt = in_lower ? S_TEST : S_FIN;
        end
      end
      S_TEST: begin
        if (tres.done) begin
          incr_nxt  = tres.prime;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_r) begin
          count_nxt = count_sum;
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_count_nxt = count_sum;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      incr_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      incr_r      <= incr_nxt;
    end
  end

  // Result register, no reset
  always_ff @(posedge clk) begin
    out_count_r <= out_count_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.prime_count = out_count_r;

  // Test results only land while a test is pending
  a_trial_in_test: assert property (@(posedge clk) disable iff (!rst_n)
    tres.done |-> state_r == S_TEST)
    else $error("primality result outside test state");

  // A new result only comes out of the finish step of a last item
  a_emit_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN) && $past(last_r))
    else $error("result raised without a last item");

  // Emitting a result clears the running count
  a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && last_r && slot_free) |=> count_r == '0)
    else $error("running count not cleared after result");

  // The count changes only at the finish step
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_FIN |=> $stable(count_r))
    else $error("running count changed outside finish step");

endmodule

### tb/tb_lower_triangle_prime_counter_unit.sv
// Testbench for lower_triangle_prime_counter_unit: directed elements and random matrices
// with a trial-division predictor in a small scoreboard class and random idling on both sides.
// Depends on ltpc_pkg, ltpc_in_if, ltpc_out_if and the unit itself from src.
module tb_lower_triangle_prime_counter_unit;
  import ltpc_pkg::*;

  localparam int DIM        = 64;
  localparam int VBITS      = 16;
  localparam int RAND_ITEMS = 1150;
  localparam int TAIL_ITEMS = 120;
  localparam int SETTLE     = 60;

  // Expected prime counts, one per matrix closed by a last element
  class prime_count_board;
    logic [COUNT_W-1:0] lower_primes;
    logic [COUNT_W-1:0] expected_counts[$];
    int mismatches;
    int counts_checked;
    int elements_seen;

    function new();
      lower_primes   = '0;
      mismatches     = 0;
      counts_checked = 0;
      elements_seen  = 0;
    endfunction

    // Trial division; sign bit set, 0 and 1 are never prime
    static function bit element_is_prime(logic [VBITS-1:0] raw);
      int unsigned v;
      int unsigned d;
      if (raw[VBITS-1]) return 1'b0;
      v = raw;
      if (v < FIRST_DIVISOR) return 1'b0;
      for (d = FIRST_DIVISOR; d * d <= v; d++) begin
        if (v % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Accepted element: count first, then close the matrix on last
    function void note_element(logic [5:0] row, logic [5:0] col, logic [VBITS-1:0] value,
                               logic last);
      elements_seen++;
      if (row < DIM && col < DIM && row > col && element_is_prime(value) &&
          lower_primes < COUNT_MAX)
        lower_primes++;
      if (last) begin
        expected_counts.push_back(lower_primes);
        lower_primes = '0;
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatches++;
    endtask

    task check_count(logic [COUNT_W-1:0] got);
      logic [COUNT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("prime count %0d with no matrix closed", got));
      end else begin
        want = expected_counts.pop_front();
        counts_checked++;
        if (got !== want)
          report_mismatch($sformatf("prime_count got %0d, expected %0d", got, want));
      end
    endtask

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   tail_quiet;
  int   send_gap_pct;
  int   stall_pct;
  int   items_sent;

  prime_count_board sb = new();

  ltpc_in_if #(.VALUE_BITS(VBITS)) in_ch ();
  ltpc_out_if out_ch ();

  lower_triangle_prime_counter_unit #(
    .MAX_DIM    (DIM),
    .VALUE_BITS (VBITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop
  initial begin
    #150_000_000;
    $display("[%0t] timeout with %0d counts outstanding", $time, sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  // Result side: ready stalls in bursts, none once the tail starts
  initial begin
    int stall_left;
    int cycle_cnt;
    stall_left = 0;
    cycle_cnt  = 0;
    stall_pct  = 5;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (cycle_cnt % 500 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 4;
          default: stall_pct = 20;
        endcase
      end
      cycle_cnt++;
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!tail_quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_count(out_ch.prime_count);
  end

  // One element; returns at the edge where it was taken, valid still high
  task send_element(input logic [5:0] row, input logic [5:0] col,
                    input logic [VBITS-1:0] value, input logic last);
    in_ch.row_index     <= row;
    in_ch.col_index     <= col;
    in_ch.element_value <= value;
    in_ch.last_element  <= last;
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_element(row, col, value, last);
    items_sent++;
  endtask

  task maybe_pause();
    if (!tail_quiet && $urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Hold off until every closed matrix has reported
  task wait_for_counts();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly small magnitudes; large positives are few since primes there are slow
  function automatic logic [VBITS-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return VBITS'($urandom_range(0, 200));
    else if (r < 60) return VBITS'(-int'($urandom_range(1, 200)));
    else if (r < 75) return VBITS'($urandom_range(0, 4095));
    else if (r < 88) return VBITS'($urandom());
    else if (r < 95) return VBITS'($urandom_range(0, 32767));
    else return VBITS'($urandom_range(32000, 32767));
  endfunction

  // Row-major matrix of size n; last mark on element number stop
  task send_matrix(input int n, input int stop);
    int idx;
    idx = 0;
    for (int r = 0; r < n && idx <= stop; r++) begin
      for (int c = 0; c < n && idx <= stop; c++) begin
        maybe_pause();
        send_element(6'(r), 6'(c), pick_value(), idx == stop);
        idx++;
      end
    end
  endtask

  // Stimulus
  initial begin
    int n;
    int kind;
    int rand_start;
    int matrices;
    in_ch.valid         <= 1'b0;
    in_ch.row_index     <= '0;
    in_ch.col_index     <= '0;
    in_ch.element_value <= '0;
    in_ch.last_element  <= 1'b0;
    rst_n        <= 1'b0;
    tail_quiet   = 1'b0;
    send_gap_pct = 0;
    items_sent   = 0;
    matrices     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: smallest and largest primes, negatives, 0 and 1, squares,
    // diagonal and upper elements, last element counted before the result
    send_element(6'd1,  6'd0,  16'sd2,      1'b0);
    send_element(6'd63, 6'd0,  16'sd32749,  1'b0);
    send_element(6'd63, 6'd62, 16'sd32767,  1'b0);
    send_element(6'd5,  6'd2,  -16'sd32768, 1'b0);
    send_element(6'd5,  6'd2,  -16'sd7,     1'b0);
    send_element(6'd5,  6'd4,  -16'sd1,     1'b0);
    send_element(6'd3,  6'd1,  16'sd0,      1'b0);
    send_element(6'd3,  6'd1,  16'sd1,      1'b0);
    send_element(6'd2,  6'd2,  16'sd7,      1'b0);
    send_element(6'd63, 6'd63, 16'sd13,     1'b0);
    send_element(6'd0,  6'd63, 16'sd13,     1'b0);
    send_element(6'd10, 6'd3,  16'sd4,      1'b0);
    send_element(6'd10, 6'd3,  16'sd9,      1'b0);
    send_element(6'd40, 6'd20, 16'sd25,     1'b0);
    send_element(6'd40, 6'd20, 16'sd3,      1'b0);
    send_element(6'd62, 6'd61, 16'sd3,      1'b1);
    send_element(6'd0,  6'd0,  16'sd5,      1'b1);
    send_element(6'd7,  6'd6,  16'sd1021,   1'b1);
    send_element(6'd63, 6'd0,  16'sd32767,  1'b1);
    send_element(6'd33, 6'd32, 16'sd21845,  1'b0);
    send_element(6'd12, 6'd11, -16'sd21846, 1'b1);
    wait_for_counts();

    // Random: mostly whole matrices, some cut short, some loose elements
    rand_start = items_sent;
    while (items_sent - rand_start < RAND_ITEMS) begin
      if (items_sent - rand_start >= RAND_ITEMS - TAIL_ITEMS) tail_quiet = 1'b1;
      case ($urandom_range(0, 2))
        0: send_gap_pct = 0;
        1: send_gap_pct = 8;
        default: send_gap_pct = 30;
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_matrix(n, n * n - 1);
        matrices++;
      end else if (kind < 85) begin
        send_matrix(n, $urandom_range(0, n * n - 1));
        matrices++;
      end else begin
        repeat ($urandom_range(1, 10)) begin
          maybe_pause();
          send_element(6'($urandom()), 6'($urandom()), pick_value(),
                       $urandom_range(0, 19) == 0);
        end
      end
      if (!tail_quiet && $urandom_range(0, 9) == 0) wait_for_counts();
    end
    // Close whatever loose elements left open
    send_element(6'($urandom()), 6'($urandom()), pick_value(), 1'b1);
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d elements: directed edge values, then %0d random matrices.",
             items_sent, matrices);
    $display("Checked %0d prime counts, %0d mismatches.", sb.counts_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### lower_triangle_prime_counter_unit.f
src/ltpc_pkg.sv
src/ltpc_in_if.sv
src/ltpc_out_if.sv
src/ltpc_rem.sv
src/ltpc_trial.sv
src/lower_triangle_prime_counter_unit.sv
tb/tb_lower_triangle_prime_counter_unit.sv
